>>> rtl/wsg_pkg.sv
package wsg_pkg;

	localparam int TICK_W = 32;
	localparam int SAMPLE_W = 12;
	localparam int MODE_W = 2;
	localparam int RATE_W = 28;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	localparam int PHASE_FRAC_BITS_DEF = 24;
	localparam int QUARTER_TABLE_DEPTH_DEF = 1024;

	localparam int ROM_W = 31;
	localparam logic [ROM_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

	localparam logic [RATE_W-1:0] RESET_CLOCK_RATE = 28'd80000000;
	localparam logic [RATE_W-1:0] RESET_WAVE_FREQ = 28'd1000;
	localparam logic [RATE_W-1:0] RESET_PERIOD = RATE_W'(80000000 / 1000);

	typedef enum logic [MODE_W-1:0] {
		MODE_SINE   = 2'd0,
		MODE_SQUARE = 2'd1,
		MODE_SAW    = 2'd2
	} wave_mode_t;

	localparam logic [MODE_W-1:0] RESET_WAVE_MODE = MODE_SQUARE;

	typedef enum logic [1:0] {
		REG_WAVE_MODE  = 2'd0,
		REG_CLOCK_RATE = 2'd1,
		REG_WAVE_FREQ  = 2'd2
	} reg_idx_t;

	// sin(x) for x in Q30 over [0, pi/2], Q30 result, Taylor series to 17th order
	function automatic logic [ROM_W-1:0] sine_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		longint acc;
		x2 = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(ONE_Q30)) begin
			acc = longint'(ONE_Q30);
		end
		return ROM_W'(acc);
	endfunction

endpackage

>>> rtl/wsg_if.sv
interface wsg_tick_if;
	import wsg_pkg::*;
	logic valid;
	logic ready;
	logic [TICK_W-1:0] tick_time;
	modport source(output valid, output tick_time, input ready);
	modport sink(input valid, input tick_time, output ready);
endinterface

interface wsg_sample_if;
	import wsg_pkg::*;
	logic valid;
	logic ready;
	logic [SAMPLE_W-1:0] sample;
	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

>>> rtl/waveform_sample_generator.sv
// Throughput: one item per cycle unless the period divider is busy or the output stalls;
// a restoring divider of one bit per stage sets the depth.
// A write to the clock rate or frequency register recomputes the period in a serial
// divider, with tick ready low meanwhile.
// Reset: registers take their reset values, the period loads its reset quotient at once,
// and the pipeline and output buffers come up empty.
module waveform_sample_generator #(
	parameter int PHASE_FRAC_BITS = wsg_pkg::PHASE_FRAC_BITS_DEF,
	parameter int QUARTER_TABLE_DEPTH = wsg_pkg::QUARTER_TABLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [wsg_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [wsg_pkg::APB_DATA_W-1:0] pwdata,
	output logic [wsg_pkg::APB_DATA_W-1:0] prdata,
	output logic pready,
	wsg_tick_if.sink tick_chan,
	wsg_sample_if.source sample_chan
);
	import wsg_pkg::*;

	localparam int F = PHASE_FRAC_BITS;
	localparam int D = QUARTER_TABLE_DEPTH;
	localparam int RW = RATE_W;
	localparam int QB = F - 2;
	localparam int DB = $clog2(D + 1);
	localparam int POS_W = QB + DB + 1;
	localparam int PROD_W = ROM_W + QB;
	localparam int SAW_W = SAMPLE_W + F;
	localparam int SCL_W = 44;
	localparam int CNT_W = $clog2(RW + 1);

	typedef logic [ROM_W-1:0] rom_t [D+1];

	function automatic rom_t build_rom();
		rom_t r;
		for (int k = 0; k <= D; k++) begin
			r[k] = sine_q30((HALF_PI_Q30 * 64'(k)) / 64'(QUARTER_TABLE_DEPTH));
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// configuration registers
	logic [MODE_W-1:0] wave_mode_q;
	logic [RW-1:0] clock_rate_q;
	logic [RW-1:0] wave_freq_q;
	logic [RW-1:0] period_q;
	logic cfg_wr;
	reg_idx_t cfg_idx;
	logic [RW-1:0] clock_next;
	logic [RW-1:0] freq_next;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign clock_next = (cfg_wr && cfg_idx == REG_CLOCK_RATE) ? pwdata[RW-1:0] : clock_rate_q;
	assign freq_next = (cfg_wr && cfg_idx == REG_WAVE_FREQ) ? pwdata[RW-1:0] : wave_freq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q <= RESET_WAVE_MODE;
			clock_rate_q <= RESET_CLOCK_RATE;
			wave_freq_q <= RESET_WAVE_FREQ;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WAVE_MODE: wave_mode_q <= pwdata[MODE_W-1:0];
				REG_CLOCK_RATE: clock_rate_q <= pwdata[RW-1:0];
				REG_WAVE_FREQ: wave_freq_q <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WAVE_MODE: prdata = APB_DATA_W'(wave_mode_q);
			REG_CLOCK_RATE: prdata = APB_DATA_W'(clock_rate_q);
			REG_WAVE_FREQ: prdata = APB_DATA_W'(wave_freq_q);
			default: prdata = '0;
		endcase
	end

	// serial period divider
	logic [CNT_W-1:0] pdiv_cnt_q;
	logic [RW-1:0] pdiv_rem_q;
	logic [RW-1:0] pdiv_num_q;
	logic [RW-1:0] pdiv_den_q;
	logic [RW:0] pdiv_sh;
	logic pdiv_ge;
	logic [RW-1:0] pdiv_quo;
	logic pdiv_busy;
	logic pdiv_start;

	assign pdiv_busy = pdiv_cnt_q != '0;
	assign pdiv_start = cfg_wr && (cfg_idx == REG_CLOCK_RATE || cfg_idx == REG_WAVE_FREQ);
	assign pdiv_sh = {pdiv_rem_q, pdiv_num_q[RW-1]};
	assign pdiv_ge = pdiv_sh >= {1'b0, pdiv_den_q};
	assign pdiv_quo = {pdiv_num_q[RW-2:0], pdiv_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pdiv_cnt_q <= '0;
			period_q <= RESET_PERIOD;
		end else if (pdiv_start) begin
			pdiv_cnt_q <= CNT_W'(RW);
		end else if (pdiv_busy) begin
			pdiv_cnt_q <= pdiv_cnt_q - 1'b1;
			if (pdiv_cnt_q == CNT_W'(1)) begin
				period_q <= (pdiv_quo == '0) ? RW'(1) : pdiv_quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pdiv_start) begin
			pdiv_rem_q <= '0;
			pdiv_num_q <= clock_next;
			pdiv_den_q <= (freq_next == '0) ? RW'(1) : freq_next;
		end else if (pdiv_busy) begin
			pdiv_rem_q <= pdiv_ge ? RW'(pdiv_sh - {1'b0, pdiv_den_q}) : pdiv_sh[RW-1:0];
			pdiv_num_q <= pdiv_quo;
		end
	end

	// output register with skid buffer
	logic out_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic skid_valid_q;
	logic [SAMPLE_W-1:0] skid_sample_q;
	logic adv;
	logic accept;

	assign adv = !skid_valid_q;
	assign tick_chan.ready = adv && !pdiv_busy;
	assign accept = tick_chan.valid && tick_chan.ready;

	// integer quotient steps: remainder of tick_time by the period
	logic int_valid_s [TICK_W];
	logic [RW-1:0] int_rem_s [TICK_W];
	logic [TICK_W-1:0] int_tick_s [TICK_W-1];

	for (genvar i = 0; i < TICK_W; i++) begin : g_int
		logic vin;
		logic [RW-1:0] rin;
		logic [TICK_W-1:0] tin;
		logic [RW:0] sh;
		logic ge;
		if (i == 0) begin : g_head
			assign vin = accept;
			assign rin = '0;
			assign tin = tick_chan.tick_time;
		end else begin : g_body
			assign vin = int_valid_s[i-1];
			assign rin = int_rem_s[i-1];
			assign tin = int_tick_s[i-1];
		end
		assign sh = {rin, tin[TICK_W-1-i]};
		assign ge = sh >= {1'b0, period_q};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				int_valid_s[i] <= 1'b0;
			end else if (adv) begin
				int_valid_s[i] <= vin;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				int_rem_s[i] <= ge ? RW'(sh - {1'b0, period_q}) : sh[RW-1:0];
			end
		end
		if (i < TICK_W - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (adv) begin
					int_tick_s[i] <= tin;
				end
			end
		end
	end

	// fraction steps: phase bits of remainder over period
	logic frac_valid_s [F];
	logic [RW-1:0] frac_rem_s [F-1];
	logic [F-1:0] frac_quo_s [F];

	for (genvar j = 0; j < F; j++) begin : g_frac
		logic vin;
		logic [RW-1:0] rin;
		logic [F-1:0] qin;
		logic [RW:0] sh;
		logic ge;
		if (j == 0) begin : g_head
			assign vin = int_valid_s[TICK_W-1];
			assign rin = int_rem_s[TICK_W-1];
			assign qin = '0;
		end else begin : g_body
			assign vin = frac_valid_s[j-1];
			assign rin = frac_rem_s[j-1];
			assign qin = frac_quo_s[j-1];
		end
		assign sh = {rin, 1'b0};
		assign ge = sh >= {1'b0, period_q};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				frac_valid_s[j] <= 1'b0;
			end else if (adv) begin
				frac_valid_s[j] <= vin;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				frac_quo_s[j] <= {qin[F-2:0], ge};
			end
		end
		if (j < F - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (adv) begin
					frac_rem_s[j] <= ge ? RW'(sh - {1'b0, period_q}) : sh[RW-1:0];
				end
			end
		end
	end

	// stage 1: fold phase into the quarter wave, table index and fraction
	logic [F-1:0] phase;
	logic [QB:0] fold_y;
	logic [POS_W-1:0] fold_pos;
	logic [DB:0] idx_full;
	logic [DB-1:0] idx_c;
	logic [QB-1:0] frac_c;

	assign phase = frac_quo_s[F-1];
	assign fold_y = phase[F-2] ? ((QB+1)'(1) << QB) - {1'b0, phase[QB-1:0]}
		: {1'b0, phase[QB-1:0]};
	assign fold_pos = POS_W'(fold_y) * POS_W'(D);
	assign idx_full = fold_pos[POS_W-1:QB];

	always_comb begin
		if (idx_full >= (DB+1)'(D)) begin
			idx_c = DB'(D);
			frac_c = '0;
		end else begin
			idx_c = idx_full[DB-1:0];
			frac_c = fold_pos[QB-1:0];
		end
	end

	logic valid_s1;
	logic [F-1:0] phase_s1;
	logic [DB-1:0] idx_s1;
	logic [QB-1:0] frac_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= frac_valid_s[F-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s1 <= phase;
			idx_s1 <= idx_c;
			frac_s1 <= frac_c;
		end
	end

	// stage 2: table read at two neighbors
	logic [DB-1:0] nxt_addr;
	logic valid_s2;
	logic [F-1:0] phase_s2;
	logic [QB-1:0] frac_s2;
	logic [ROM_W-1:0] cur_s2;
	logic [ROM_W-1:0] nxt_s2;

	assign nxt_addr = (idx_s1 < DB'(D)) ? idx_s1 + 1'b1 : idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s2 <= phase_s1;
			frac_s2 <= frac_s1;
			cur_s2 <= SINE_ROM[idx_s1];
			nxt_s2 <= SINE_ROM[nxt_addr];
		end
	end

	// stage 3: interpolation step
	logic [ROM_W-1:0] diff;
	logic [PROD_W-1:0] interp_prod;
	logic valid_s3;
	logic [F-1:0] phase_s3;
	logic [ROM_W-1:0] cur_s3;
	logic [ROM_W-1:0] step_s3;

	assign diff = (nxt_s2 > cur_s2) ? nxt_s2 - cur_s2 : '0;
	assign interp_prod = PROD_W'(diff) * PROD_W'(frac_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s3 <= phase_s2;
			cur_s3 <= cur_s2;
			step_s3 <= interp_prod[PROD_W-1:QB];
		end
	end

	// stage 4: scale and select the waveform
	logic [ROM_W:0] sin_v;
	logic [ROM_W:0] sin_vc;
	logic [ROM_W:0] sin_u;
	logic [SCL_W-1:0] sin_scaled;
	logic [SAW_W-1:0] saw_scaled;
	logic [SAMPLE_W-1:0] sample_c;
	logic valid_s4;
	logic [SAMPLE_W-1:0] sample_s4;

	assign sin_v = {1'b0, cur_s3} + {1'b0, step_s3};
	assign sin_vc = (sin_v > {1'b0, ONE_Q30}) ? {1'b0, ONE_Q30} : sin_v;
	assign sin_u = phase_s3[F-1] ? {1'b0, ONE_Q30} - sin_vc : {1'b0, ONE_Q30} + sin_vc;
	assign sin_scaled = SCL_W'(sin_u) * SCL_W'(FULL_SCALE) + SCL_W'(ONE_Q30);
	assign saw_scaled = SAW_W'(phase_s3) * SAW_W'(FULL_SCALE);

	always_comb begin
		case (wave_mode_q)
			MODE_SINE: sample_c = sin_scaled[SAMPLE_W+30:31];
			MODE_SAW: sample_c = saw_scaled[SAW_W-1:F];
			default: sample_c = phase_s3[F-1] ? '0 : FULL_SCALE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s4 <= sample_c;
		end
	end

	logic push;
	logic take;

	assign push = adv && valid_s4;
	assign take = out_valid_q && sample_chan.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			out_sample_q <= skid_valid_q ? skid_sample_q : sample_s4;
		end else if (push) begin
			skid_sample_q <= sample_s4;
		end
	end

	assign sample_chan.valid = out_valid_q;
	assign sample_chan.sample = out_sample_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid buffer holds an item while the output register is empty");

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		period_q != '0)
		else $error("period register is zero");

	a_stall_holds_tail: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && skid_valid_q |=> valid_s4 && $stable(sample_s4))
		else $error("last pipeline stage changed while stalled");

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		pdiv_start |=> !tick_chan.ready)
		else $error("tick accepted while the period is recomputed");
`endif

endmodule

>>> tb/waveform_sample_generator_tb.sv
module waveform_sample_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wsg_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int FRAC = PHASE_FRAC_BITS_DEF;
	localparam int QDEPTH = QUARTER_TABLE_DEPTH_DEF;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
	localparam logic [63:0] FULL = 64'd4095;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	localparam int HOLD_AT = 40;
	localparam int HOLD_CYCLES = 240;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	wsg_tick_if tick_bus();
	wsg_sample_if sample_bus();

	waveform_sample_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.tick_chan(tick_bus),
		.sample_chan(sample_bus)
	);

	logic [MODE_W-1:0] cfg_mode;
	logic [RATE_W-1:0] cfg_rate;
	logic [RATE_W-1:0] cfg_freq;
	logic [63:0] sine_tab [0:QDEPTH];

	logic [TICK_W-1:0] pending_ticks[$];
	logic [SAMPLE_W-1:0] expected_samples[$];
	int mismatches = 0;
	int ticks_taken;
	int gap_left;
	int stall_left;
	int hold_left;
	bit hold_done;
	bit no_idle = 1'b0;

	always begin
		#HALF_PERIOD clk = ~clk;
	end

	function automatic logic [63:0] taylor_sine(logic [63:0] x);
		logic [63:0] xsq;
		logic [63:0] term;
		longint acc;
		xsq = (x * x) >> 30;
		term = x;
		acc = longint'(x);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * xsq) >> 30) / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc -= longint'(term);
			end else begin
				acc += longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > longint'(Q30_ONE)) begin
			acc = longint'(Q30_ONE);
		end
		return 64'(acc);
	endfunction

	initial begin
		for (int k = 0; k <= QDEPTH; k++) begin
			sine_tab[k] = taylor_sine((QUARTER_TURN_Q30 * 64'(k)) / 64'(QDEPTH));
		end
	end

	function automatic logic [63:0] period_ticks();
		logic [63:0] divisor;
		logic [63:0] quot;
		divisor = (cfg_freq == 0) ? 64'd1 : 64'(cfg_freq);
		quot = 64'(cfg_rate) / divisor;
		return (quot == 0) ? 64'd1 : quot;
	endfunction

	function automatic logic [SAMPLE_W-1:0] sine_level(logic [63:0] phase);
		logic [63:0] quarter;
		logic [63:0] quad;
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] pos;
		logic [63:0] idx;
		logic [63:0] frac;
		logic [63:0] cur;
		logic [63:0] nxt;
		logic [63:0] v;
		logic [63:0] u;
		quarter = 64'd1 << (FRAC - 2);
		quad = (phase >> (FRAC - 2)) & 64'd3;
		x = phase & (quarter - 1);
		y = quad[0] ? quarter - x : x;
		pos = y * 64'(QDEPTH);
		idx = pos >> (FRAC - 2);
		frac = pos & (quarter - 1);
		if (idx >= QDEPTH) begin
			idx = QDEPTH;
			frac = 0;
		end
		cur = sine_tab[idx];
		nxt = (idx < QDEPTH) ? sine_tab[idx + 1] : cur;
		v = cur;
		if (nxt > cur) begin
			v += ((nxt - cur) * frac) >> (FRAC - 2);
		end
		if (v > Q30_ONE) begin
			v = Q30_ONE;
		end
		u = (quad >= 2) ? Q30_ONE - v : Q30_ONE + v;
		return SAMPLE_W'((FULL * u + Q30_ONE) >> 31);
	endfunction

	function automatic logic [SAMPLE_W-1:0] expected_sample(logic [TICK_W-1:0] t);
		logic [63:0] per;
		logic [63:0] phase;
		per = period_ticks();
		phase = ((64'(t) % per) << FRAC) / per;
		case (cfg_mode)
			MODE_SINE: return sine_level(phase);
			MODE_SAW: return SAMPLE_W'((FULL * phase) >> FRAC);
			default: return (phase < (64'd1 << (FRAC - 1))) ? SAMPLE_W'(FULL) : '0;
		endcase
	endfunction

	function automatic logic [TICK_W-1:0] next_tick();
		logic [63:0] per;
		logic [63:0] off;
		per = period_ticks();
		case ($urandom_range(0, 5))
			0: off = 0;
			1: off = per / 2;
			2: off = (per > 1) ? per / 2 - 1 : 0;
			3: off = per - 1;
			4: off = 1;
			default: off = 64'($urandom) % per;
		endcase
		case ($urandom_range(0, 3))
			0, 1: return $urandom;
			2: return TICK_W'(per * 64'($urandom_range(0, 40)) + off);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic write_reg(reg_idx_t which, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (which)
			REG_WAVE_MODE: cfg_mode = value[MODE_W-1:0];
			REG_CLOCK_RATE: cfg_rate = value[RATE_W-1:0];
			REG_WAVE_FREQ: cfg_freq = value[RATE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_ticks.size() != 0 || tick_bus.valid || expected_samples.size() != 0);
	endtask

	task automatic random_config();
		logic [31:0] rate;
		logic [31:0] freq;
		logic [31:0] f;
		case ($urandom_range(0, 5))
			0: begin
				rate = $urandom_range(1, 200000000);
				freq = $urandom_range(1, 200000000);
			end
			1, 2: begin
				f = $urandom_range(1, 2000);
				rate = f * $urandom_range(1, 5000) + $urandom_range(0, f - 1);
				freq = f;
			end
			3: begin
				rate = $urandom_range(1, 32'(RATE_MAX));
				freq = $urandom_range(1, 1000);
			end
			4: begin
				rate = 32'(RATE_MAX);
				freq = $urandom_range(0, 3);
			end
			default: begin
				rate = $urandom;
				freq = $urandom;
			end
		endcase
		write_reg(REG_WAVE_MODE, $urandom);
		write_reg(REG_CLOCK_RATE, rate);
		write_reg(REG_WAVE_FREQ, freq);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_bus.valid <= 1'b0;
			gap_left <= 0;
			ticks_taken <= 0;
		end else begin
			if (tick_bus.valid && tick_bus.ready) begin
				expected_samples.push_back(expected_sample(tick_bus.tick_time));
				ticks_taken <= ticks_taken + 1;
			end
			if (!tick_bus.valid || tick_bus.ready) begin
				if (gap_left > 0) begin
					tick_bus.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_ticks.size() > 0) begin
					if (!no_idle && $urandom_range(0, 19) == 0) begin
						tick_bus.valid <= 1'b0;
						gap_left <= $urandom_range(0, 10);
					end else begin
						tick_bus.tick_time <= pending_ticks.pop_front();
						tick_bus.valid <= 1'b1;
					end
				end else begin
					tick_bus.valid <= 1'b0;
				end
			end
		end
	end

	// hold off the sample side once long enough to back up the pipeline
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && ticks_taken >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bus.ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (sample_bus.valid && sample_bus.ready) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected sample %0d", $realtime, sample_bus.sample);
					end
				end else begin
					if (sample_bus.sample !== expected_samples[0]) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: sample mismatch: expected %0d, got %0d", $realtime,
								expected_samples[0], sample_bus.sample);
						end
					end
					void'(expected_samples.pop_front());
				end
			end
			if (hold_left > 0) begin
				sample_bus.ready <= 1'b0;
			end else if (stall_left > 0) begin
				sample_bus.ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!no_idle && $urandom_range(0, 15) == 0) begin
				sample_bus.ready <= 1'b0;
				stall_left <= $urandom_range(0, 10);
			end else begin
				sample_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL waveform_sample_generator");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_bus.valid = 1'b0;
		tick_bus.tick_time = '0;
		sample_bus.ready = 1'b0;
		cfg_mode = RESET_WAVE_MODE;
		cfg_rate = RESET_CLOCK_RATE;
		cfg_freq = RESET_WAVE_FREQ;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		pending_ticks = '{32'd0, 32'd39999, 32'd40000, 32'd79999, 32'd80000, 32'hFFFF_FFFF};
		wait_drained();

		write_reg(REG_WAVE_MODE, MODE_SINE);
		write_reg(REG_CLOCK_RATE, 32'd4096);
		write_reg(REG_WAVE_FREQ, 32'd1);
		pending_ticks = '{32'd0, 32'd1024, 32'd2048, 32'd3072, 32'd4095, 32'd512};
		wait_drained();

		write_reg(REG_WAVE_MODE, MODE_SAW);
		pending_ticks = '{32'd0, 32'd4095, 32'd2047};
		wait_drained();

		write_reg(REG_WAVE_MODE, MODE_SPARE);
		pending_ticks = '{32'd1000, 32'd3000};
		wait_drained();

		// zero frequency
		write_reg(REG_WAVE_MODE, MODE_SAW);
		write_reg(REG_CLOCK_RATE, 32'd5);
		write_reg(REG_WAVE_FREQ, 32'd0);
		pending_ticks = '{32'd3, 32'd4};
		wait_drained();

		// clock rate below frequency, then zero clock rate
		write_reg(REG_WAVE_MODE, MODE_SINE);
		write_reg(REG_CLOCK_RATE, 32'd3);
		write_reg(REG_WAVE_FREQ, 32'd7);
		pending_ticks = '{32'd12345};
		wait_drained();
		write_reg(REG_CLOCK_RATE, 32'd0);
		pending_ticks = '{32'd99};
		wait_drained();

		// upper data bits beyond each register width must be dropped
		write_reg(REG_WAVE_MODE, {30'h3FFF_FFFF, MODE_SAW});
		write_reg(REG_CLOCK_RATE, 32'hFFFF_FFFF);
		write_reg(REG_WAVE_FREQ, 32'hF000_0001);
		pending_ticks = '{32'hFFFF_FFFF, 32'h0FFF_FFFE};
		wait_drained();

		for (int p = 0; p < 6; p++) begin
			random_config();
			if (p == 5) begin
				no_idle = 1'b1;
			end
			repeat ((p == 0) ? 150 : 50) begin
				pending_ticks.push_back(next_tick());
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS waveform_sample_generator");
		end else begin
			$display("FAIL waveform_sample_generator");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/wsg_pkg.sv
rtl/wsg_if.sv
rtl/waveform_sample_generator.sv
tb/waveform_sample_generator_tb.sv
